[src/dbd_pkg.sv]
// ----------------------------------------------------------------------------
// dbd_pkg - shared types and constants for the Gregorian day counter
// Date word layout, status codes, month length table and the date checks
// used by the sequencer and the day walker.
// ----------------------------------------------------------------------------
package dbd_pkg;

   // Field widths of one date and of the day count
   localparam int unsigned DayWidth   = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 14;
   localparam int unsigned CountWidth = 22;

   // Highest year accepted as valid
   localparam logic [YearWidth-1:0] MAX_YEAR = 14'd9999;

   // Month codes that the stepper tests against
   localparam logic [MonthWidth-1:0] MONTH_JAN = 4'd1;
   localparam logic [MonthWidth-1:0] MONTH_FEB = 4'd2;
   localparam logic [MonthWidth-1:0] MONTH_DEC = 4'd12;

   // Divide-by-25 reciprocal: floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT for y < 2**14
   localparam int unsigned RecipShift = 19;
   localparam int unsigned ProdWidth  = YearWidth + 15;
   localparam logic [14:0] RECIP_25   = 15'd20972;

   // Result status codes
   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_START = 2'd1;
   localparam status_type STATUS_BAD_END   = 2'd2;

   // One calendar date; packed so that a plain compare orders valid dates
   typedef struct packed {
      logic [YearWidth-1:0]  year;
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
   } date_type;

   // Controls from the sequencer to the day walker
   typedef struct packed {
      logic load;
      logic step;
   } walk_ctrl_type;

   // Days per month in a common year; codes that are no month give 0
   localparam logic [DayWidth-1:0] MONTH_LEN [16] = '{
      5'd0,  5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0,  5'd0,  5'd0
   };

   // Length of a month, February stretched in a leap year
   function automatic logic [DayWidth-1:0] month_days(input logic [MonthWidth-1:0] month,
                                                      input logic leap);
      logic [DayWidth-1:0] len;
      len = MONTH_LEN[month];
      if (month == MONTH_FEB && leap) begin
         len = 5'd29;
      end
      return len;
   endfunction

   // Year in range, month known, day between 1 and the month length
   function automatic logic date_valid(input date_type d, input logic leap);
      return (d.year <= MAX_YEAR) && (d.day != '0) && (d.day <= month_days(d.month, leap));
   endfunction

endpackage

[src/dbd_leap.sv]
// ----------------------------------------------------------------------------
// dbd_leap - two-stage leap year unit
// Takes a year each cycle and gives its leap flag from the second stage. The
// divide-by-25 test uses a reciprocal product, registered before the check.
// ----------------------------------------------------------------------------
module dbd_leap (
   input  logic                           clock,
   input  logic [dbd_pkg::YearWidth-1:0]  year,
   output logic                           leap
);

   logic [dbd_pkg::YearWidth-1:0] year_ff;
   logic [dbd_pkg::ProdWidth-1:0] prod_ff;
   logic [dbd_pkg::ProdWidth-1:0] prod_in;
   logic                          leap_ff;
   logic                          leap_in;
   logic [9:0]                    quot;
   logic [dbd_pkg::YearWidth-1:0] mult25;
   logic                          div25;

   // Stage one: reciprocal product
   assign prod_in = dbd_pkg::ProdWidth'(year) * dbd_pkg::ProdWidth'(dbd_pkg::RECIP_25);

   always_ff @(posedge clock) begin
      year_ff <= year;
      prod_ff <= prod_in;
   end

   // Stage two: rebuild quotient times 25 and test divisibility
   assign quot   = prod_ff[dbd_pkg::ProdWidth-1:dbd_pkg::RecipShift];
   assign mult25 = dbd_pkg::YearWidth'({quot, 4'b0000}) + dbd_pkg::YearWidth'({quot, 3'b000})
                 + dbd_pkg::YearWidth'(quot);
   assign div25  = (mult25 == year_ff);

   // Leap: by 4, and not by 100 unless by 400 (by 100 = by 4 and 25, by 400 = by 16 and 25)
   assign leap_in = (year_ff[1:0] == 2'b00) && (!div25 || (year_ff[3:0] == 4'b0000));

   always_ff @(posedge clock) begin
      leap_ff <= leap_in;
   end

   assign leap = leap_ff;

endmodule

[src/dbd_walk.sv]
// ----------------------------------------------------------------------------
// dbd_walk - day walker
// Holds the walking date, the target date and the step count. Advances the
// walking date by one calendar day per step and reports whether it is
// still earlier than the target.
// ----------------------------------------------------------------------------
module dbd_walk (
   input  logic                            clock,
   input  dbd_pkg::walk_ctrl_type          ctrl,
   input  dbd_pkg::date_type               start_date,
   input  dbd_pkg::date_type               end_date,
   input  logic                            leap,
   output dbd_pkg::date_type               walk_date,
   output dbd_pkg::date_type               target_date,
   output logic [dbd_pkg::CountWidth-1:0]  day_count,
   output logic                            earlier
);

   dbd_pkg::date_type               walk_ff;
   dbd_pkg::date_type               walk_in;
   dbd_pkg::date_type               target_ff;
   dbd_pkg::date_type               next_date;
   logic [dbd_pkg::CountWidth-1:0]  count_ff;
   logic [dbd_pkg::CountWidth-1:0]  count_in;
   logic                            last_day;

   // Next calendar day after the walking date
   assign last_day = (walk_ff.day == dbd_pkg::month_days(walk_ff.month, leap));

   always_comb begin
      next_date = walk_ff;
      if (last_day) begin
         next_date.day = 5'd1;
         if (walk_ff.month == dbd_pkg::MONTH_DEC) begin
            next_date.month = dbd_pkg::MONTH_JAN;
            next_date.year  = walk_ff.year + 1'b1;
         end else begin
            next_date.month = walk_ff.month + 1'b1;
         end
      end else begin
         next_date.day = walk_ff.day + 1'b1;
      end
   end

   // Load a new pair, advance one day, or hold
   always_comb begin
      walk_in  = walk_ff;
      count_in = count_ff;
      if (ctrl.load) begin
         walk_in  = start_date;
         count_in = '0;
      end else if (ctrl.step) begin
         walk_in  = next_date;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff  <= walk_in;
      count_ff <= count_in;
      if (ctrl.load) begin
         target_ff <= end_date;
      end
   end

   assign walk_date   = walk_ff;
   assign target_date = target_ff;
   assign day_count   = count_ff;
   assign earlier     = (walk_ff < target_ff);

endmodule

[src/days_between_dates_counter.sv]
// ----------------------------------------------------------------------------
// days_between_dates_counter - Gregorian day counter, top level
// Counts the days from a start date to an end date by walking one day a
// cycle, with a validity check on both dates.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the six req_ date fields and raise start; the word is taken at the
//   clock edge where start is high and busy is low. busy then stays high
//   until the result is issued.
//   States LEAP_S, LEAP_E, VAL_S and VAL_E fetch both leap flags and check
//   both dates. An invalid date ends the job there. Otherwise the walker
//   advances one day per cycle through the step and compare unit until the
//   walking date reaches the end date.
//   An invalid date gives its result from VAL_E; a valid pair gives it from
//   WALK once the walking date is no longer earlier, with a count of 0 when
//   the start is not earlier than the end. One job at a time; a new word
//   may be given in the cycle that rsp_valid is high.
//   rsp_valid is high for one cycle with rsp_day_count and rsp_status; the
//   receiver has no way to hold it off and must take it then.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   any job in progress without a result.
// ----------------------------------------------------------------------------
module days_between_dates_counter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dbd_pkg::DayWidth-1:0]    req_start_day,
   input  logic [dbd_pkg::MonthWidth-1:0]  req_start_month,
   input  logic [dbd_pkg::YearWidth-1:0]   req_start_year,
   input  logic [dbd_pkg::DayWidth-1:0]    req_end_day,
   input  logic [dbd_pkg::MonthWidth-1:0]  req_end_month,
   input  logic [dbd_pkg::YearWidth-1:0]   req_end_year,
   output logic                            rsp_valid,
   output logic [dbd_pkg::CountWidth-1:0]  rsp_day_count,
   output logic [1:0]                      rsp_status
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LEAP_S = 3'd1;
   localparam logic [2:0] ST_LEAP_E = 3'd2;
   localparam logic [2:0] ST_VAL_S  = 3'd3;
   localparam logic [2:0] ST_VAL_E  = 3'd4;
   localparam logic [2:0] ST_WALK   = 3'd5;

   logic [2:0]                      state_ff;
   logic [2:0]                      state_in;
   logic                            start_ok_ff;
   logic                            start_ok_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [dbd_pkg::CountWidth-1:0]  rsp_count_ff;
   logic [dbd_pkg::CountWidth-1:0]  rsp_count_in;
   dbd_pkg::status_type             rsp_status_ff;
   dbd_pkg::status_type             rsp_status_in;

   dbd_pkg::walk_ctrl_type          walk_ctrl;
   dbd_pkg::date_type               req_start_date;
   dbd_pkg::date_type               req_end_date;
   dbd_pkg::date_type               walk_date;
   dbd_pkg::date_type               target_date;
   logic [dbd_pkg::CountWidth-1:0]  walk_count;
   logic                            earlier;
   logic [dbd_pkg::YearWidth-1:0]   leap_year_sel;
   logic                            leap;
   logic                            accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign req_start_date = '{year: req_start_year, month: req_start_month, day: req_start_day};
   assign req_end_date   = '{year: req_end_year, month: req_end_month, day: req_end_day};

   // Feed the end year only in its slot; the walking year otherwise
   assign leap_year_sel = (state_ff == ST_LEAP_E) ? target_date.year : walk_date.year;

   dbd_leap u_leap (
      .clock (clock),
      .year  (leap_year_sel),
      .leap  (leap)
   );

   dbd_walk u_walk (
      .clock       (clock),
      .ctrl        (walk_ctrl),
      .start_date  (req_start_date),
      .end_date    (req_end_date),
      .leap        (leap),
      .walk_date   (walk_date),
      .target_date (target_date),
      .day_count   (walk_count),
      .earlier     (earlier)
   );

   // Sequence: load, fetch leap flags, check dates, walk if both are valid, issue result
   always_comb begin
      state_in       = state_ff;
      start_ok_in    = start_ok_ff;
      rsp_valid_in   = 1'b0;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      walk_ctrl.load = 1'b0;
      walk_ctrl.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               walk_ctrl.load = 1'b1;
               state_in       = ST_LEAP_S;
            end
         end
         ST_LEAP_S: begin
            state_in = ST_LEAP_E;
         end
         ST_LEAP_E: begin
            state_in = ST_VAL_S;
         end
         ST_VAL_S: begin
            start_ok_in = dbd_pkg::date_valid(walk_date, leap);
            state_in    = ST_VAL_E;
         end
         ST_VAL_E: begin
            if (!start_ok_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = '0;
               rsp_status_in = dbd_pkg::STATUS_BAD_START;
               state_in      = ST_IDLE;
            end else if (!dbd_pkg::date_valid(target_date, leap)) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = '0;
               rsp_status_in = dbd_pkg::STATUS_BAD_END;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (earlier) begin
               walk_ctrl.step = 1'b1;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = walk_count;
               rsp_status_in = dbd_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      start_ok_ff   <= start_ok_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_day_count = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

[src/dbd_checker.sv]
// ----------------------------------------------------------------------------
// dbd_checker - port checks for the Gregorian day counter
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module dbd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [dbd_pkg::CountWidth-1:0]  rsp_day_count,
   input logic [1:0]                      rsp_status
);

   // An accepted word makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accept");

   // A result strobe lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // Busy drops only when a result is issued
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // A failed date check carries a zero count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != dbd_pkg::STATUS_OK) |-> (rsp_day_count == '0))
      else $error("non-zero count with bad status");

   // Status is one of the three defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == dbd_pkg::STATUS_OK) || (rsp_status == dbd_pkg::STATUS_BAD_START)
                    || (rsp_status == dbd_pkg::STATUS_BAD_END))
      else $error("undefined status code");

endmodule

bind days_between_dates_counter dbd_checker u_dbd_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_day_count (rsp_day_count),
   .rsp_status    (rsp_status)
);
